[rtl/bpfm_pkg.sv]
// ----------------------------------------------------------------------------
// bpfm_pkg
// Shared types, opcodes and status codes of the buffer pool frame manager.
// ----------------------------------------------------------------------------
`default_nettype none
package bpfm_pkg;

	localparam int FRAMES_DEF       = 64;
	localparam int PAGE_ID_BITS_DEF = 32;
	localparam int PIN_BITS_DEF     = 16;

	localparam logic [2:0] OP_FETCH    = 3'd0;
	localparam logic [2:0] OP_UNPIN    = 3'd1;
	localparam logic [2:0] OP_FLUSH    = 3'd2;
	localparam logic [2:0] OP_DIRTY    = 3'd3;
	localparam logic [2:0] OP_ALLOC    = 3'd4;

	localparam logic [2:0] ST_HIT      = 3'd0;
	localparam logic [2:0] ST_LOADED   = 3'd1;
	localparam logic [2:0] ST_EVICTED  = 3'd2;
	localparam logic [2:0] ST_ALLPIN   = 3'd3;
	localparam logic [2:0] ST_DONE     = 3'd4;
	localparam logic [2:0] ST_NOTRES   = 3'd5;
	localparam logic [2:0] ST_ALLOC    = 3'd6;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [31:0] page_id;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  frame_index;
		logic        write_back;
		logic [31:0] write_page_id;
		logic        read_request;
		logic [31:0] new_page_id;
	} rsp_t;

endpackage
`default_nettype wire

[rtl/bpfm_front.sv]
// ----------------------------------------------------------------------------
// bpfm_front
// Accepts commands, looks the page up over the frame table one frame per cycle
// (alloc skips the lookup) and queues the classified command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module bpfm_front #(
	parameter int FRAMES       = bpfm_pkg::FRAMES_DEF,
	parameter int PAGE_ID_BITS = bpfm_pkg::PAGE_ID_BITS_DEF,
	localparam int FW = $clog2(FRAMES)
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	input  bpfm_pkg::req_t       req,
	output logic                 busy,
	// lookup port into the back end's tables
	output logic [FW-1:0]        look_idx,
	input  wire                  look_res,
	input  wire [PAGE_ID_BITS-1:0] look_page,
	// queue to the back end
	output logic                 q_valid,
	output logic [2:0]           q_op,
	output logic [PAGE_ID_BITS-1:0] q_pid,
	output logic                 q_hit,
	output logic [FW-1:0]        q_frame,
	input  wire                  q_pop
);
	localparam logic [1:0] S_IDLE = 2'd0, S_SCAN = 2'd1, S_WAIT = 2'd2;

	logic [1:0]              state_q;
	logic [2:0]              op_q;
	logic [PAGE_ID_BITS-1:0] pid_q;
	logic [FW-1:0]           idx_q;
	logic [FW-1:0]           cmp_idx_s1;
	logic                    cmp_vld_s1;
	logic                    match;

	assign look_idx = idx_q;
	// lookup data is registered and arrives the cycle after its address
	assign match    = cmp_vld_s1 && look_res && (look_page == pid_q);
	assign busy     = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			q_valid    <= 1'b0;
			idx_q      <= '0;
			cmp_idx_s1 <= '0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			cmp_vld_s1 <= (state_q == S_SCAN);
			cmp_idx_s1 <= idx_q;
			if (q_pop)
				q_valid <= 1'b0;
			case (state_q)
				S_IDLE: if (start) begin
					op_q  <= req.opcode;
					pid_q <= PAGE_ID_BITS'(req.page_id);
					idx_q <= '0;
					if (req.opcode <= bpfm_pkg::OP_DIRTY)
						state_q <= S_SCAN;
					else begin
						q_op    <= req.opcode;
						q_hit   <= 1'b0;
						q_frame <= '0;
						q_valid <= 1'b1;
						state_q <= S_WAIT;
					end
				end
				S_SCAN: begin
					// first matching frame wins; only one can match
					if (cmp_vld_s1 && (match || cmp_idx_s1 == FW'(FRAMES-1))) begin
						q_op    <= op_q;
						q_pid   <= pid_q;
						q_hit   <= match;
						q_frame <= cmp_idx_s1;
						q_valid <= 1'b1;
						state_q <= S_WAIT;
					end else if (idx_q != FW'(FRAMES-1))
						idx_q <= idx_q + 1'b1;
				end
				S_WAIT: if (q_pop)
					state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[rtl/bpfm_back.sv]
// ----------------------------------------------------------------------------
// bpfm_back
// Carries out classified commands: pin counts, dirty bits, the LRU list and
// victim selection, and drives the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none
module bpfm_back #(
	parameter int FRAMES       = bpfm_pkg::FRAMES_DEF,
	parameter int PAGE_ID_BITS = bpfm_pkg::PAGE_ID_BITS_DEF,
	parameter int PIN_BITS     = bpfm_pkg::PIN_BITS_DEF,
	localparam int FW = $clog2(FRAMES)
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire [FW-1:0]         look_idx,
	output logic                 look_res,
	output logic [PAGE_ID_BITS-1:0] look_page,
	input  wire                  q_valid,
	input  wire [2:0]            q_op,
	input  wire [PAGE_ID_BITS-1:0] q_pid,
	input  wire                  q_hit,
	input  wire [FW-1:0]         q_frame,
	output logic                 q_pop,
	output logic                 done,
	output bpfm_pkg::rsp_t       rsp
);
	localparam logic [2:0] B_IDLE = 3'd0, B_RD = 3'd1, B_EXEC = 3'd2,
		B_LRM = 3'd3, B_LAPP = 3'd4;
	localparam logic [PIN_BITS-1:0] PIN_MAX = '1;

	logic [PAGE_ID_BITS-1:0] page_mem [FRAMES];
	logic [PIN_BITS-1:0]     pins_mem [FRAMES];
	logic                    dirty_mem [FRAMES];
	logic [FW-1:0]           lru_mem [FRAMES];
	logic [FW:0]             lru_cnt_q, next_q, rd_i_q, wr_j_q;
	logic [PAGE_ID_BITS-1:0] cnt_q, vpage_q;
	logic [PIN_BITS-1:0]     pin_rd_q;
	logic                    dirty_rd_q;
	logic [FW-1:0]           lru_rd_q, tgt_q, head_q, sel_frame;
	logic [2:0]              bst_q, exec_nx;
	logic                    keep;
	bpfm_pkg::rsp_t          rsp_d;
	logic                    page_we, pin_we, dirty_we, dirty_wd;
	logic [FW-1:0]           page_wa, pin_wa, dirty_wa, tgt_d;
	logic [PIN_BITS-1:0]     pin_wd;

	function automatic logic [31:0] pid32(input logic [PAGE_ID_BITS-1:0] p);
		logic [63:0] w;
		w = 64'(p);
		return w[31:0];
	endfunction

	// hits (fetch, unpin, flush, mark dirty) work on the looked-up frame, evictions on the LRU head
	assign sel_frame = q_hit ? q_frame : head_q;
	// compaction keeps the entry read on the previous cycle unless it is tgt
	assign keep = (rd_i_q != '0) && ((rd_i_q - 1'b1) < lru_cnt_q) && (lru_rd_q != tgt_q);

	// frames below the fill count are resident; table entries need no reset
	always_ff @(posedge clk) begin
		look_page  <= page_mem[look_idx];
		look_res   <= ({1'b0, look_idx} < next_q);
		lru_rd_q   <= lru_mem[rd_i_q[FW-1:0]];
		head_q     <= lru_mem[0];
		vpage_q    <= page_mem[sel_frame];
		pin_rd_q   <= pins_mem[sel_frame];
		dirty_rd_q <= dirty_mem[sel_frame];
		if (bst_q == B_EXEC && page_we)
			page_mem[page_wa] <= q_pid;
		if (bst_q == B_EXEC && pin_we)
			pins_mem[pin_wa] <= pin_wd;
		if (bst_q == B_EXEC && dirty_we)
			dirty_mem[dirty_wa] <= dirty_wd;
		if (bst_q == B_LRM && keep)
			lru_mem[wr_j_q[FW-1:0]] <= lru_rd_q;
		if (bst_q == B_LAPP)
			lru_mem[lru_cnt_q[FW-1:0]] <= tgt_q;
	end

	always_comb begin
		rsp_d = '0;
		rsp_d.status = bpfm_pkg::ST_DONE;
		exec_nx  = B_IDLE;
		tgt_d    = q_frame;
		page_we  = 1'b0;
		page_wa  = next_q[FW-1:0];
		pin_we   = 1'b0;
		pin_wa   = q_frame;
		pin_wd   = pin_rd_q;
		dirty_we = 1'b0;
		dirty_wa = q_frame;
		dirty_wd = 1'b0;
		case (q_op)
			bpfm_pkg::OP_FETCH: begin
				if (q_hit) begin
					rsp_d.status = bpfm_pkg::ST_HIT;
					rsp_d.frame_index = 6'(q_frame);
					if (pin_rd_q != PIN_MAX) begin
						pin_we = 1'b1;
						pin_wd = pin_rd_q + 1'b1;
					end
					if (pin_rd_q == '0)
						exec_nx = B_LRM;
				end else if (next_q < (FW+1)'(FRAMES)) begin
					rsp_d.status = bpfm_pkg::ST_LOADED;
					rsp_d.frame_index = 6'(next_q);
					rsp_d.read_request = 1'b1;
					page_we  = 1'b1;
					pin_we   = 1'b1;
					pin_wa   = next_q[FW-1:0];
					pin_wd   = PIN_BITS'(1);
					dirty_we = 1'b1;
					dirty_wa = next_q[FW-1:0];
				end else if (lru_cnt_q != '0) begin
					rsp_d.status = bpfm_pkg::ST_EVICTED;
					rsp_d.frame_index = 6'(head_q);
					rsp_d.read_request = 1'b1;
					rsp_d.write_back = dirty_rd_q;
					if (dirty_rd_q)
						rsp_d.write_page_id = pid32(vpage_q);
					page_we  = 1'b1;
					page_wa  = head_q;
					pin_we   = 1'b1;
					pin_wa   = head_q;
					pin_wd   = PIN_BITS'(1);
					dirty_we = 1'b1;
					dirty_wa = head_q;
					tgt_d    = head_q;
					exec_nx  = B_LRM;
				end else
					rsp_d.status = bpfm_pkg::ST_ALLPIN;
			end
			bpfm_pkg::OP_UNPIN, bpfm_pkg::OP_FLUSH,
			bpfm_pkg::OP_DIRTY: begin
				if (!q_hit)
					rsp_d.status = bpfm_pkg::ST_NOTRES;
				else if (q_op == bpfm_pkg::OP_UNPIN) begin
					if (pin_rd_q != '0) begin
						pin_we = 1'b1;
						pin_wd = pin_rd_q - 1'b1;
						if (pin_rd_q == PIN_BITS'(1) && lru_cnt_q < (FW+1)'(FRAMES))
							exec_nx = B_LAPP;
					end
				end else if (q_op == bpfm_pkg::OP_FLUSH) begin
					if (dirty_rd_q) begin
						rsp_d.write_back = 1'b1;
						rsp_d.write_page_id = pid32(vpage_q);
						dirty_we = 1'b1;
					end
				end else begin
					dirty_we = 1'b1;
					dirty_wd = 1'b1;
				end
			end
			bpfm_pkg::OP_ALLOC: begin
				rsp_d.status = bpfm_pkg::ST_ALLOC;
				rsp_d.new_page_id = pid32(cnt_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bst_q <= B_IDLE; lru_cnt_q <= '0; next_q <= '0; cnt_q <= '0;
			q_pop <= 1'b0; done <= 1'b0; rd_i_q <= '0; wr_j_q <= '0;
			tgt_q <= '0; rsp <= '0;
		end else begin
			case (bst_q)
				B_IDLE: begin
					q_pop <= 1'b0;
					done  <= 1'b0;
					if (q_valid && !q_pop)
						bst_q <= B_RD;
				end
				B_RD: begin
					// let head, pins, dirty and page reads settle
					q_pop <= 1'b0;
					done  <= 1'b0;
					bst_q <= B_EXEC;
				end
				B_EXEC: begin
					rsp    <= rsp_d;
					tgt_q  <= tgt_d;
					rd_i_q <= '0;
					wr_j_q <= '0;
					bst_q  <= exec_nx;
					q_pop  <= (exec_nx == B_IDLE);
					done   <= (exec_nx == B_IDLE);
					if (q_op == bpfm_pkg::OP_FETCH && !q_hit && next_q < (FW+1)'(FRAMES))
						next_q <= next_q + 1'b1;
					if (q_op == bpfm_pkg::OP_ALLOC)
						cnt_q <= cnt_q + 1'b1;
				end
				B_LRM: begin
					// compact the list one entry a cycle, dropping tgt
					if (keep)
						wr_j_q <= wr_j_q + 1'b1;
					if (rd_i_q >= lru_cnt_q + 1'b1 || rd_i_q == (FW+1)'(FRAMES)) begin
						lru_cnt_q <= wr_j_q + (FW+1)'(keep);
						bst_q <= B_IDLE; q_pop <= 1'b1; done <= 1'b1;
					end else begin
						rd_i_q <= rd_i_q + 1'b1;
						q_pop <= 1'b0; done <= 1'b0;
					end
				end
				B_LAPP: begin
					lru_cnt_q <= lru_cnt_q + 1'b1;
					bst_q <= B_IDLE; q_pop <= 1'b1; done <= 1'b1;
				end
				default: begin
					bst_q <= B_IDLE; q_pop <= 1'b0; done <= 1'b0;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

[rtl/buffer_pool_frame_manager.sv]
// Fetch, unpin, flush and mark dirty first look the page up over the frame
// table, one frame per cycle behind a registered table read. Unpin to zero adds
// an LRU append; a fetch hit on an unpinned frame or an eviction adds an LRU
// compaction. One command at a time: busy drops the cycle after the strobe.
// Reset clears the counters; frame entries are written on load.
// ----------------------------------------------------------------------------
// buffer_pool_frame_manager
// Page frame pool with least recently unpinned replacement.
// ----------------------------------------------------------------------------
`default_nettype none
module buffer_pool_frame_manager #(
	parameter int FRAMES       = bpfm_pkg::FRAMES_DEF,
	parameter int PAGE_ID_BITS = bpfm_pkg::PAGE_ID_BITS_DEF,
	parameter int PIN_BITS     = bpfm_pkg::PIN_BITS_DEF
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             start,
	input  bpfm_pkg::req_t  req,
	output logic            busy,
	output logic            done,
	output bpfm_pkg::rsp_t  rsp
);
	localparam int FW = $clog2(FRAMES);
	logic [FW-1:0]           look_idx, q_frame;
	logic                    look_res, q_valid, q_hit, q_pop;
	logic [PAGE_ID_BITS-1:0] look_page, q_pid;
	logic [2:0]              q_op;

	bpfm_front #(.FRAMES(FRAMES), .PAGE_ID_BITS(PAGE_ID_BITS)) u_front (
		.clk, .arst_n, .start, .req, .busy, .look_idx, .look_res, .look_page,
		.q_valid, .q_op, .q_pid, .q_hit, .q_frame, .q_pop);

	bpfm_back #(.FRAMES(FRAMES), .PAGE_ID_BITS(PAGE_ID_BITS), .PIN_BITS(PIN_BITS))
	u_back (
		.clk, .arst_n, .look_idx, .look_res, .look_page, .q_valid, .q_op, .q_pid,
		.q_hit, .q_frame, .q_pop, .done, .rsp);

`ifndef SYNTHESIS
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without command");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop of empty queue");
	a_no_start: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid |-> busy) else $error("queue entry while idle");
`endif
endmodule
`default_nettype wire
